FILE: rtl/led_tone_blink_sequencer_assert.svh
// Assertion macros for the blink sequencer checker.
// Self-contained; included by the checker file only.
`ifndef LED_TONE_BLINK_SEQUENCER_ASSERT_SVH
`define LED_TONE_BLINK_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LTBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blink sequencer check failed");

// next-cycle implication, disabled in reset
`define LTBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blink sequencer check failed");

`endif

FILE: rtl/lbs_pkg.sv
// Types and constants of the LED and tone blink sequencer.
// No dependencies; imported by the channel unit, the output register and the top level.
`default_nettype none
package lbs_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_DONE
  } st_t;

  localparam logic       REG_SOUND_ENABLE = 1'b0;
  localparam logic       REG_BRIGHTNESS   = 1'b1;
  localparam logic       SOUND_RESET      = 1'b1;
  localparam logic [5:0] BRIGHT_RESET     = 6'd50;

  typedef struct packed {
    logic [1:0] red;
    logic [1:0] green;
    logic [1:0] blue;
    logic [6:0] on_duration;
    logic [6:0] off_duration;
    logic [7:0] repeat_count;
    logic [7:0] base_note;
    logic [7:0] note_increment;
  } cmd_t;

  typedef struct packed {
    logic       ph;
    logic [6:0] fc;
    cmd_t       cmd;
  } chan_t;

  typedef struct packed {
    logic       led_write;
    logic [1:0] red;
    logic [1:0] green;
    logic [1:0] blue;
    logic       tone_start;
    logic [7:0] tone_note;
    logic       tone_stop;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/lbs_chan_unit.sv
// Shared channel step unit: advances one channel by one frame tick.
// Depends on lbs_pkg; used once by the top level, one channel per cycle.
`default_nettype none
module lbs_chan_unit (
  input  lbs_pkg::chan_t ch_in,
  input  logic           is_owner,
  input  logic           lit_in,
  input  logic           sound_en,
  input  lbs_pkg::res_t  acc_in,
  output lbs_pkg::chan_t ch_out,
  output logic           lit_out,
  output logic           take_owner,
  output lbs_pkg::res_t  acc_out
);
  import lbs_pkg::*;

  logic hold_fc;

  always_comb begin
    ch_out     = ch_in;
    lit_out    = lit_in;
    take_owner = 1'b0;
    acc_out    = acc_in;
    hold_fc    = 1'b0;
    if (ch_in.cmd.repeat_count != 8'd0) begin
      if (ch_in.ph && ch_in.fc == ch_in.cmd.on_duration) begin
        ch_out.ph               = 1'b0;
        ch_out.fc               = 7'd0;
        ch_out.cmd.repeat_count = ch_in.cmd.repeat_count - 8'd1;
        if (is_owner) begin
          if (lit_in) begin
            acc_out.led_write = 1'b1;
            acc_out.red       = 2'd0;
            acc_out.green     = 2'd0;
            acc_out.blue      = 2'd0;
            lit_out           = 1'b0;
          end
          if (ch_in.cmd.base_note != 8'd0) begin
            acc_out.tone_start = 1'b0;
            acc_out.tone_note  = 8'd0;
            acc_out.tone_stop  = 1'b1;
          end
        end
        if (ch_in.cmd.off_duration != 7'd0) begin
          ch_out.fc = 7'd1;
          hold_fc   = 1'b1;
        end
      end
      if (!hold_fc && !ch_out.ph && ch_out.cmd.repeat_count != 8'd0 &&
          ch_out.fc == ch_in.cmd.off_duration) begin
        ch_out.ph = 1'b1;
        ch_out.fc = 7'd0;
        if (ch_in.cmd.red != 2'd0 || ch_in.cmd.green != 2'd0 ||
            ch_in.cmd.blue != 2'd0) begin
          lit_out           = 1'b1;
          acc_out.led_write = 1'b1;
          acc_out.red       = ch_in.cmd.red;
          acc_out.green     = ch_in.cmd.green;
          acc_out.blue      = ch_in.cmd.blue;
        end
        take_owner = 1'b1;
        if (sound_en && ch_in.cmd.base_note != 8'd0) begin
          acc_out.tone_start   = 1'b1;
          acc_out.tone_note    = ch_in.cmd.base_note;
          acc_out.tone_stop    = 1'b0;
          ch_out.cmd.base_note = ch_in.cmd.base_note + ch_in.cmd.note_increment;
        end
      end
      if (!hold_fc) begin
        ch_out.fc = ch_out.fc + 7'd1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lbs_out_reg.sv
// Output register: scales the colour levels by brightness and holds the word.
// Depends on lbs_pkg; parts the sequencer from the result receiver.
`default_nettype none
module lbs_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lbs_pkg::res_t res_in,
  input  logic [5:0]    brightness,
  output logic          can_push,
  input  logic          out_ready,
  output logic          out_valid,
  output logic          out_led_write,
  output logic [7:0]    out_led_red,
  output logic [7:0]    out_led_green,
  output logic [7:0]    out_led_blue,
  output logic          out_tone_start,
  output logic [7:0]    out_tone_note,
  output logic          out_tone_stop
);
  import lbs_pkg::*;

  logic       valid_r;
  logic       write_r, start_r, stop_r;
  logic [7:0] red_r, green_r, blue_r, note_r;
  logic [7:0] br_ext;

  assign br_ext   = {2'b00, brightness};
  assign can_push = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      write_r <= res_in.led_write;
      red_r   <= {6'd0, res_in.red} * br_ext;
      green_r <= {6'd0, res_in.green} * br_ext;
      blue_r  <= {6'd0, res_in.blue} * br_ext;
      start_r <= res_in.tone_start;
      note_r  <= res_in.tone_note;
      stop_r  <= res_in.tone_stop;
    end
  end

  assign out_valid      = valid_r;
  assign out_led_write  = write_r;
  assign out_led_red    = red_r;
  assign out_led_green  = green_r;
  assign out_led_blue   = blue_r;
  assign out_tone_start = start_r;
  assign out_tone_note  = note_r;
  assign out_tone_stop  = stop_r;

endmodule
`default_nettype wire

FILE: rtl/led_tone_blink_sequencer.sv
// Top level of the LED and tone blink sequencer: sequencer, channel store, config.
// Depends on lbs_pkg, lbs_chan_unit and lbs_out_reg.
//
// Input channel (in_valid/in_ready) takes one word per command: a frame tick,
// a start that loads a channel, or a clear of one channel or of all of them.
// Every input word gives exactly one result word on out_valid/out_ready: the
// final LED write (colour level times brightness) and the last tone start or
// stop caused by that word.
// A start or clear passes from the result word through the done state to the
// output register; the next word can be taken once the sequencer is back in idle.
// A tick walks the channels through one shared step unit, one channel a
// cycle in the tick state, then passes through the done state to the output
// register; in_ready is high only in idle.
// The output register holds a finished word while the next input is taken;
// if the receiver stalls, the following word waits in the sequencer until
// the register frees, and in_ready stays low meanwhile.
// cfg_we writes sound_enable (index 0) or brightness (index 1) at once;
// write only while no word is in flight.
// Synchronous reset clears all channels, gives the LED to channel 0, unlit,
// and sets sound_enable to 1 and brightness to 50.
`default_nettype none
module led_tone_blink_sequencer #(
  parameter int CHANNELS = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [1:0] in_buffer_select,
  input  logic [1:0] in_red,
  input  logic [1:0] in_green,
  input  logic [1:0] in_blue,
  input  logic [6:0] in_on_duration,
  input  logic [6:0] in_off_duration,
  input  logic [7:0] in_repeat_count,
  input  logic [7:0] in_base_note,
  input  logic [7:0] in_note_increment,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_led_write,
  output logic [7:0] out_led_red,
  output logic [7:0] out_led_green,
  output logic [7:0] out_led_blue,
  output logic       out_tone_start,
  output logic [7:0] out_tone_note,
  output logic       out_tone_stop,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_wdata
);
  import lbs_pkg::*;

  localparam int              CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);
  localparam logic [3:0]      CH_CNT  = 4'(CHANNELS);

  st_t             state_r, state_nxt;
  logic [CH_W-1:0] ch_r;
  chan_t           chan_r [CHANNELS];
  logic [CH_W-1:0] owner_r;
  logic            lit_r;
  res_t            acc_r, acc_nxt;
  logic            se_r;
  logic [5:0]      bright_r;

  logic            accept, push, can_push;
  logic [CH_W-1:0] sel_idx;
  logic            sel_ok, clr_all, clr_one, turn_off;
  chan_t           unit_in, unit_out;
  logic            unit_lit, unit_take;
  res_t            unit_acc;

  assign accept  = in_valid && in_ready;
  assign sel_idx = CH_W'(in_buffer_select);
  assign sel_ok  = {2'b00, in_buffer_select} < CH_CNT;
  assign clr_all = (in_mode == MODE_CLEAR) && ({2'b00, in_buffer_select} == CH_CNT);
  assign clr_one = (in_mode == MODE_CLEAR) && sel_ok;
  assign turn_off = clr_all || (clr_one && owner_r == sel_idx);
  assign unit_in = chan_r[ch_r];

  lbs_chan_unit u_unit (
    .ch_in      (unit_in),
    .is_owner   (owner_r == ch_r),
    .lit_in     (lit_r),
    .sound_en   (se_r),
    .acc_in     (acc_r),
    .ch_out     (unit_out),
    .lit_out    (unit_lit),
    .take_owner (unit_take),
    .acc_out    (unit_acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    push      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = (in_mode == MODE_TICK) ? ST_TICK : ST_DONE;
        end
      end
      ST_TICK: begin
        if (ch_r == CH_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_push) begin
          push      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      se_r     <= SOUND_RESET;
      bright_r <= BRIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOUND_ENABLE: se_r     <= cfg_wdata[0];
        REG_BRIGHTNESS:   bright_r <= cfg_wdata;
        default:          se_r     <= se_r;
      endcase
    end
  end

  // channel store, LED owner and walk counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r    <= '0;
      owner_r <= '0;
      lit_r   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_r[i] <= '0;
      end
    end else if (accept) begin
      ch_r <= '0;
      if (in_mode == MODE_START && sel_ok) begin
        chan_r[sel_idx] <= '{ph: 1'b0, fc: 7'd0,
                             cmd: '{red: in_red, green: in_green, blue: in_blue,
                                    on_duration: in_on_duration,
                                    off_duration: in_off_duration,
                                    repeat_count: in_repeat_count,
                                    base_note: in_base_note,
                                    note_increment: in_note_increment}};
      end
      if (clr_all) begin
        for (int i = 0; i < CHANNELS; i++) begin
          chan_r[i].cmd <= '0;
        end
      end else if (clr_one) begin
        chan_r[sel_idx].cmd <= '0;
      end
      if (turn_off) begin
        lit_r <= 1'b0;
      end
    end else if (state_r == ST_TICK) begin
      chan_r[ch_r] <= unit_out;
      lit_r        <= unit_lit;
      if (unit_take) begin
        owner_r <= ch_r;
      end
      ch_r <= ch_r + CH_W'(1);
    end
  end

  // result word of the item in flight
  always_comb begin
    acc_nxt = acc_r;
    if (accept) begin
      acc_nxt = '0;
      if (turn_off) begin
        acc_nxt.led_write = lit_r;
        acc_nxt.tone_stop = 1'b1;
      end
    end else if (state_r == ST_TICK) begin
      acc_nxt = unit_acc;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  lbs_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .res_in         (acc_r),
    .brightness     (bright_r),
    .can_push       (can_push),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_led_write  (out_led_write),
    .out_led_red    (out_led_red),
    .out_led_green  (out_led_green),
    .out_led_blue   (out_led_blue),
    .out_tone_start (out_tone_start),
    .out_tone_note  (out_tone_note),
    .out_tone_stop  (out_tone_stop)
  );

endmodule
`default_nettype wire

FILE: rtl/lbs_checker.sv
// Port-level checker for the blink sequencer, bound to the top level.
// Depends on led_tone_blink_sequencer_assert.svh.
`default_nettype none
`include "led_tone_blink_sequencer_assert.svh"
module lbs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_led_write,
  input logic [7:0] out_led_red,
  input logic [7:0] out_led_green,
  input logic [7:0] out_led_blue,
  input logic       out_tone_start,
  input logic [7:0] out_tone_note,
  input logic       out_tone_stop
);

  `LTBS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `LTBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_tone_note))
  `LTBS_ASSERT_NOW(a_dark_no_colour, clk, rst_n, out_valid && !out_led_write, out_led_red == 8'd0 && out_led_green == 8'd0 && out_led_blue == 8'd0)
  `LTBS_ASSERT_NOW(a_tone_excl, clk, rst_n, out_valid, !(out_tone_start && out_tone_stop))
  `LTBS_ASSERT_NOW(a_note_only_on_start, clk, rst_n, out_valid && !out_tone_start, out_tone_note == 8'd0)

endmodule

bind led_tone_blink_sequencer lbs_checker u_lbs_checker (.*);
`default_nettype wire

FILE: tb/sv/led_tone_blink_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for led_tone_blink_sequencer: directed and random words
// on the input channel, results checked against a predictor kept in this file.
// Depends on lbs_pkg and the RTL of the block.
module led_tone_blink_sequencer_test;
  import lbs_pkg::*;

  localparam int         CHANNELS     = 2;
  localparam int         SEL_ALL      = CHANNELS;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         SETTLE       = CHANNELS + 6;
  localparam int         RANDOM_WORDS = 160;

  typedef struct {
    logic [1:0] mode;
    logic [1:0] sel;
    cmd_t       cmd;
  } seq_word_t;

  typedef struct packed {
    logic       led_write;
    logic [7:0] led_red;
    logic [7:0] led_green;
    logic [7:0] led_blue;
    logic       tone_start;
    logic [7:0] tone_note;
    logic       tone_stop;
  } led_tone_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_mode;
  logic [1:0] in_buffer_select;
  logic [1:0] in_red;
  logic [1:0] in_green;
  logic [1:0] in_blue;
  logic [6:0] in_on_duration;
  logic [6:0] in_off_duration;
  logic [7:0] in_repeat_count;
  logic [7:0] in_base_note;
  logic [7:0] in_note_increment;
  logic       out_valid;
  logic       out_ready;
  logic       out_led_write;
  logic [7:0] out_led_red;
  logic [7:0] out_led_green;
  logic [7:0] out_led_blue;
  logic       out_tone_start;
  logic [7:0] out_tone_note;
  logic       out_tone_stop;
  logic       cfg_we;
  logic       cfg_index;
  logic [5:0] cfg_wdata;

  cmd_t       chan_cmd    [CHANNELS];
  logic       chan_phase  [CHANNELS];
  logic [6:0] chan_frames [CHANNELS];
  int         led_owner_ch;
  logic       led_on;
  logic       sound_on;
  logic [5:0] bright_level;
  led_tone_t  acc;

  led_tone_t  led_tone_q[$];
  led_tone_t  want_word;
  int         fail_count;
  logic       tx_idle;
  logic       rx_idle;
  int         hold_cycles_req;

  led_tone_blink_sequencer #(.CHANNELS(CHANNELS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_buffer_select(in_buffer_select),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .in_on_duration(in_on_duration), .in_off_duration(in_off_duration),
    .in_repeat_count(in_repeat_count), .in_base_note(in_base_note),
    .in_note_increment(in_note_increment),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_led_write(out_led_write), .out_led_red(out_led_red),
    .out_led_green(out_led_green), .out_led_blue(out_led_blue),
    .out_tone_start(out_tone_start), .out_tone_note(out_tone_note),
    .out_tone_stop(out_tone_stop),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void reset_predictor();
    for (int i = 0; i < CHANNELS; i++) begin
      chan_cmd[i]    = '0;
      chan_phase[i]  = 1'b0;
      chan_frames[i] = '0;
    end
    led_owner_ch = 0;
    led_on       = 1'b0;
    sound_on     = SOUND_RESET;
    bright_level = BRIGHT_RESET;
  endfunction

  function automatic void write_led(logic [1:0] r, logic [1:0] g, logic [1:0] b);
    acc.led_write = 1'b1;
    acc.led_red   = {6'd0, r} * {2'd0, bright_level};
    acc.led_green = {6'd0, g} * {2'd0, bright_level};
    acc.led_blue  = {6'd0, b} * {2'd0, bright_level};
  endfunction

  function automatic void stop_note();
    acc.tone_start = 1'b0;
    acc.tone_note  = '0;
    acc.tone_stop  = 1'b1;
  endfunction

  function automatic void darken_led();
    if (led_on) begin
      write_led(2'd0, 2'd0, 2'd0);
      led_on = 1'b0;
    end
  endfunction

  function automatic led_tone_t predict_led_tone(seq_word_t w);
    logic rest;
    logic turn_off;
    acc = '0;
    turn_off = 1'b0;
    case (w.mode)
      MODE_TICK: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (chan_cmd[i].repeat_count != 0) begin
            rest = 1'b1;
            if (chan_phase[i] && chan_frames[i] == chan_cmd[i].on_duration) begin
              chan_phase[i]  = 1'b0;
              chan_frames[i] = '0;
              chan_cmd[i].repeat_count = chan_cmd[i].repeat_count - 8'd1;
              if (led_owner_ch == i) begin
                darken_led();
                if (chan_cmd[i].base_note != 0) stop_note();
              end
              if (chan_cmd[i].off_duration != 0) begin
                chan_frames[i] = 7'd1;
                rest = 1'b0;
              end
            end
            if (rest) begin
              if (!chan_phase[i] && chan_cmd[i].repeat_count != 0 &&
                  chan_frames[i] == chan_cmd[i].off_duration) begin
                chan_phase[i]  = 1'b1;
                chan_frames[i] = '0;
                if (chan_cmd[i].red != 0 || chan_cmd[i].green != 0 ||
                    chan_cmd[i].blue != 0) begin
                  led_on = 1'b1;
                  write_led(chan_cmd[i].red, chan_cmd[i].green, chan_cmd[i].blue);
                end
                led_owner_ch = i;
                if (sound_on && chan_cmd[i].base_note != 0) begin
                  acc.tone_start = 1'b1;
                  acc.tone_note  = chan_cmd[i].base_note;
                  acc.tone_stop  = 1'b0;
                  chan_cmd[i].base_note = chan_cmd[i].base_note +
                                          chan_cmd[i].note_increment;
                end
              end
              chan_frames[i] = chan_frames[i] + 7'd1;
            end
          end
        end
      end
      MODE_START: begin
        if (w.sel < CHANNELS) begin
          chan_phase[w.sel]  = 1'b0;
          chan_frames[w.sel] = '0;
          chan_cmd[w.sel]    = w.cmd;
        end
      end
      MODE_CLEAR: begin
        if (w.sel == SEL_ALL) begin
          for (int i = 0; i < CHANNELS; i++) chan_cmd[i] = '0;
          turn_off = 1'b1;
        end else if (w.sel < CHANNELS) begin
          chan_cmd[w.sel] = '0;
          turn_off = (led_owner_ch == w.sel);
        end
        if (turn_off) begin
          darken_led();
          stop_note();
        end
      end
      default: ;
    endcase
    return acc;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (led_tone_q.size() == 0) begin
        $error("result word with nothing outstanding");
        fail_count++;
      end else begin
        want_word = led_tone_q.pop_front();
        check_field("led_write", want_word.led_write, out_led_write);
        check_field("led_red", want_word.led_red, out_led_red);
        check_field("led_green", want_word.led_green, out_led_green);
        check_field("led_blue", want_word.led_blue, out_led_blue);
        check_field("tone_start", want_word.tone_start, out_tone_start);
        check_field("tone_note", want_word.tone_note, out_tone_note);
        check_field("tone_stop", want_word.tone_stop, out_tone_stop);
      end
    end
  end

  // hold off the receiver for the requested count, else stall at random while rx_idle is set
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles_req > 0) begin
        out_ready = 1'b0;
        repeat (hold_cycles_req) @(negedge clk);
        hold_cycles_req = 0;
      end
      out_ready = !(rx_idle && $urandom_range(99) < 17);
    end
  end

  function automatic seq_word_t make_word(logic [1:0] mode, logic [1:0] sel,
                                          logic [1:0] r, logic [1:0] g, logic [1:0] b,
                                          logic [6:0] on_d, logic [6:0] off_d,
                                          logic [7:0] rep, logic [7:0] note,
                                          logic [7:0] step);
    seq_word_t w;
    w.mode = mode;
    w.sel  = sel;
    w.cmd  = '{r, g, b, on_d, off_d, rep, note, step};
    return w;
  endfunction

  function automatic seq_word_t random_word();
    seq_word_t   w;
    logic [63:0] bits;
    int          pick;
    bits   = {$urandom, $urandom};
    w.cmd  = bits[43:0];
    w.sel  = bits[45:44];
    w.mode = bits[47:46];
    pick   = $urandom_range(99);
    if (pick < 68) begin
      w.mode = MODE_TICK;
    end else if (pick < 84) begin
      w.mode = MODE_START;
      w.sel  = 2'($urandom_range(CHANNELS - 1));
      w.cmd.on_duration  = 7'($urandom_range(6));
      w.cmd.off_duration = 7'($urandom_range(6));
      w.cmd.repeat_count = 8'($urandom_range(1, 6));
      if ($urandom_range(4) == 0) w.cmd.base_note = '0;
      if ($urandom_range(7) == 0) begin
        w.cmd.red   = '0;
        w.cmd.green = '0;
        w.cmd.blue  = '0;
      end
    end else if (pick < 91) begin
      w.mode = MODE_CLEAR;
    end else if (pick < 96) begin
      w.mode = MODE_START;
    end else begin
      w.mode = MODE_UNUSED;
    end
    return w;
  endfunction

  task automatic send_word(input seq_word_t w);
    while (tx_idle && $urandom_range(99) < 17) @(negedge clk);
    in_valid          = 1'b1;
    in_mode           = w.mode;
    in_buffer_select  = w.sel;
    in_red            = w.cmd.red;
    in_green          = w.cmd.green;
    in_blue           = w.cmd.blue;
    in_on_duration    = w.cmd.on_duration;
    in_off_duration   = w.cmd.off_duration;
    in_repeat_count   = w.cmd.repeat_count;
    in_base_note      = w.cmd.base_note;
    in_note_increment = w.cmd.note_increment;
    do @(posedge clk); while (!in_ready);
    led_tone_q.push_back(predict_led_tone(w));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_word(make_word(MODE_TICK, '0, '0, '0, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic wait_drained();
    while (led_tone_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [5:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_SOUND_ENABLE) sound_on = data[0];
    else bright_level = data;
  endtask

  task automatic set_config(input logic snd, input logic [5:0] level);
    wait_drained();
    write_reg(REG_SOUND_ENABLE, {5'($urandom), snd});
    write_reg(REG_BRIGHTNESS, level);
  endtask

  task automatic test_idle_commands();
    send_word(make_word(MODE_UNUSED, 2'd3, 2'd3, 2'd3, 2'd3, 7'd127, 7'd127,
                        8'd255, 8'd255, 8'd255));
    send_ticks(1);
    send_word(make_word(MODE_CLEAR, 2'(SEL_ALL), '0, '0, '0, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_CLEAR, 2'd3, '0, '0, '0, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_START, 2'd3, 2'd1, 2'd1, 2'd1, 7'd0, 7'd0, 8'd1, 8'd9, 8'd1));
    send_word(make_word(MODE_START, 2'(SEL_ALL), 2'd2, 2'd2, 2'd2, 7'd0, 7'd0,
                        8'd1, 8'd9, 8'd1));
    send_ticks(1);
  endtask

  task automatic test_blink_basics();
    send_word(make_word(MODE_START, 2'd0, 2'd3, 2'd3, 2'd3, 7'd1, 7'd0,
                        8'd2, 8'd255, 8'd255));
    send_word(make_word(MODE_START, 2'd1, 2'd0, 2'd0, 2'd0, 7'd2, 7'd1,
                        8'd1, 8'd0, 8'd0));
    send_ticks(6);
    send_word(make_word(MODE_CLEAR, 2'd1, '0, '0, '0, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_CLEAR, 2'd0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_START, 2'd0, 2'd1, 2'd2, 2'd0, 7'd127, 7'd127,
                        8'd255, 8'd1, 8'd128));
    send_word(make_word(MODE_START, 2'd1, 2'd2, 2'd0, 2'd1, 7'd3, 7'd0,
                        8'd3, 8'd40, 8'd3));
    send_ticks(3);
    send_word(make_word(MODE_CLEAR, 2'd1, '0, '0, '0, '0, '0, '0, '0, '0));
    send_word(make_word(MODE_CLEAR, 2'(SEL_ALL), '0, '0, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic test_counter_wrap();
    send_word(make_word(MODE_START, 2'd0, 2'd2, 2'd1, 2'd3, 7'd0, 7'd0,
                        8'd2, 8'd60, 8'd12));
    send_ticks(262);
    send_word(make_word(MODE_CLEAR, 2'(SEL_ALL), '0, '0, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic test_config_extremes();
    set_config(1'b0, 6'd63);
    send_word(make_word(MODE_START, 2'd0, 2'd3, 2'd3, 2'd3, 7'd1, 7'd0,
                        8'd4, 8'd10, 8'd1));
    send_ticks(4);
    set_config(1'b1, 6'd0);
    send_ticks(4);
    send_word(make_word(MODE_CLEAR, 2'(SEL_ALL), '0, '0, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_cycles_req = 80;
    repeat (16) send_word(random_word());
  endtask

  task automatic test_sender_pause();
    repeat (20) send_word(random_word());
    wait_drained();
    repeat (20) send_word(random_word());
  endtask

  task automatic test_no_idle_stretch();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (200) send_word(random_word());
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_traffic();
    set_config(1'b1, 6'd63);
    repeat (RANDOM_WORDS) send_word(random_word());
    set_config(1'b0, 6'd0);
    repeat (RANDOM_WORDS) send_word(random_word());
    set_config(1'b1, 6'd1);
    repeat (RANDOM_WORDS) send_word(random_word());
    set_config(1'b0, 6'($urandom));
    repeat (RANDOM_WORDS) send_word(random_word());
    set_config(1'b1, 6'($urandom));
    repeat (RANDOM_WORDS) send_word(random_word());
    set_config(1'b1, BRIGHT_RESET);
    repeat (RANDOM_WORDS) send_word(random_word());
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_mode           = '0;
    in_buffer_select  = '0;
    in_red            = '0;
    in_green          = '0;
    in_blue           = '0;
    in_on_duration    = '0;
    in_off_duration   = '0;
    in_repeat_count   = '0;
    in_base_note      = '0;
    in_note_increment = '0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    fail_count        = 0;
    tx_idle           = 1'b1;
    rx_idle           = 1'b1;
    hold_cycles_req   = 0;
    reset_predictor();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_commands();
    test_blink_basics();
    test_counter_wrap();
    test_config_extremes();
    test_backpressure();
    test_sender_pause();
    test_no_idle_stretch();
    test_random_traffic();
    wait_drained();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/lbs_pkg.sv
rtl/lbs_chan_unit.sv
rtl/lbs_out_reg.sv
rtl/led_tone_blink_sequencer.sv
rtl/lbs_checker.sv
tb/sv/led_tone_blink_sequencer_test.sv
